// File: rtl/krc4_pkg.sv
// ---------------------------------------------------------------------------
// krc4_pkg
// Shared types, constants and command/status structs for the keyed RC4
// keystream generator.
// ---------------------------------------------------------------------------
package krc4_pkg;

   localparam int SUBKEY_BYTES_DEF = 65536;
   localparam int MAX_FETCH_DEF    = 64;
   localparam int KEY_TAIL_GAP     = 89;
   localparam int STORE_DEPTH      = 65536;
   localparam int STORE_AW         = 16;
   localparam int PERM_DEPTH       = 256;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_FETCH = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] key_address;
      logic [7:0]  key_byte;
      logic [6:0]  fetch_count;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_KS_RD,
      ST_KS_J,
      ST_KS_SW,
      ST_KS_T,
      ST_GEN_A,
      ST_GEN_B,
      ST_GEN_SW,
      ST_GEN_T,
      ST_GEN_OUT,
      ST_GEN_RSP
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic store_wr;
      logic init_clear;
      logic init_step;
      logic ks_rd;
      logic ks_j;
      logic ks_sw;
      logic ks_t;
      logic gen_a;
      logic gen_b;
      logic gen_sw;
      logic gen_t;
      logic gen_out;
      logic gen_rsp;
      logic fetch_begin;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic init_done;
      logic ks_done;
      logic skipping;
      logic run_done;
   } sts_type;

endpackage

// File: rtl/krc4_ram.sv
// ---------------------------------------------------------------------------
// krc4_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module krc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, or registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/krc4_datapath.sv
// ---------------------------------------------------------------------------
// krc4_datapath
// Permutation store, subkey store, indices and block position; carries out
// the controller's commands with one access to each memory per cycle.
// ---------------------------------------------------------------------------
module krc4_datapath import krc4_pkg::*; #(
   parameter int SUBKEY_BYTES = SUBKEY_BYTES_DEF,
   parameter int MAX_FETCH    = MAX_FETCH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);

   localparam int PW = $clog2(SUBKEY_BYTES) + 1;
   localparam logic [PW-1:0] BLOCK_END = PW'(SUBKEY_BYTES);
   localparam logic [STORE_AW-1:0] KEY_BASE =
      STORE_AW'(SUBKEY_BYTES - PERM_DEPTH - KEY_TAIL_GAP);

   logic [7:0]    a_ff, a_in, b_ff, b_in;
   logic [7:0]    i_ff, i_in;
   logic [8:0]    cnt_ff, cnt_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [6:0]    left_ff, left_in;
   logic          skip_ff, skip_in;
   logic [7:0]    sa_ff, sa_in, sb_ff, sb_in;

   logic                perm_we;
   logic [7:0]          perm_addr, perm_wd, perm_rd;
   logic                st_we;
   logic [STORE_AW-1:0] st_addr;
   logic [7:0]          st_rd;
   logic [6:0]          cnt_sat;
   logic [PW-1:0]       room;
   logic [7:0]          j_sum;

   assign cnt_sat = (req.fetch_count > 7'(MAX_FETCH)) ? 7'(MAX_FETCH) : req.fetch_count;
   assign room    = BLOCK_END - pos_ff;
   // key schedule index: j + S[i] + key byte
   assign j_sum   = b_ff + perm_rd + st_rd;

   krc4_ram #(.WIDTH(8), .DEPTH(PERM_DEPTH)) u_perm (
      .clock(clock), .wr_en(perm_we), .addr(perm_addr),
      .wr_data(perm_wd), .rd_data(perm_rd)
   );

   krc4_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .wr_en(st_we), .addr(st_addr),
      .wr_data(req.key_byte), .rd_data(st_rd)
   );

   // memory addressing per command
   always_comb begin
      perm_we   = 1'b0;
      perm_addr = i_ff;
      perm_wd   = i_ff;
      st_we     = cmd.store_wr;
      st_addr   = req.key_address;
      if (cmd.init_step) begin
         perm_we = 1'b1;
      end else if (cmd.ks_rd) begin
         perm_addr = i_ff;
         st_addr   = KEY_BASE + STORE_AW'(i_ff);
      end else if (cmd.ks_j) begin
         perm_addr = j_sum;
      end else if (cmd.ks_sw) begin
         // swap: S[j] into slot i, then S[i] into slot j
         perm_we   = 1'b1;
         perm_addr = i_ff;
         perm_wd   = perm_rd;
      end else if (cmd.ks_t) begin
         perm_we   = 1'b1;
         perm_addr = b_ff;
         perm_wd   = sa_ff;
      end else if (cmd.gen_a) begin
         perm_addr = a_ff + 8'd1;
      end else if (cmd.gen_b) begin
         perm_addr = b_ff + perm_rd;
      end else if (cmd.gen_sw) begin
         perm_we   = 1'b1;
         perm_addr = a_ff;
         perm_wd   = perm_rd;
      end else if (cmd.gen_t) begin
         perm_we   = 1'b1;
         perm_addr = b_ff;
         perm_wd   = sa_ff;
      end else if (cmd.gen_out) begin
         perm_addr = sa_ff + sb_ff;
         st_addr   = STORE_AW'(pos_ff);
      end
   end

   // register updates
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      i_in    = i_ff;
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      left_in = left_ff;
      skip_in = skip_ff;
      sa_in   = sa_ff;
      sb_in   = sb_ff;
      if (cmd.init_clear) begin
         i_in   = '0;
         cnt_in = '0;
      end
      if (cmd.init_step || cmd.ks_t) begin
         i_in   = i_ff + 8'd1;
         cnt_in = cnt_ff + 9'd1;
      end
      // key schedule: ks_j takes S[i] and the key byte, forms j
      if (cmd.ks_j) begin
         sa_in = perm_rd;
         b_in  = j_sum;
      end
      if (cmd.fetch_begin) begin
         left_in = cnt_sat;
         if (room == '0) begin
            // block already used up: nothing to walk, start a new block
            pos_in  = '0;
            skip_in = 1'b0;
         end else begin
            skip_in = (PW'(cnt_sat) > room);
         end
      end
      if (cmd.gen_a) begin
         a_in = a_ff + 8'd1;
      end
      if (cmd.gen_b) begin
         sa_in = perm_rd;
         b_in  = b_ff + perm_rd;
      end
      if (cmd.gen_sw) begin
         sb_in = perm_rd;
      end
      if (cmd.gen_rsp) begin
         if (skip_ff) begin
            if (pos_ff == BLOCK_END - PW'(1)) begin
               pos_in  = '0;
               skip_in = 1'b0;
            end else begin
               pos_in = pos_ff + PW'(1);
            end
         end else begin
            pos_in  = pos_ff + PW'(1);
            left_in = left_ff - 7'd1;
         end
      end
      if (cmd.init_clear) begin
         a_in   = '0;
         b_in   = '0;
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff    <= '0;
         b_ff    <= '0;
         pos_ff  <= '0;
         skip_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         pos_ff  <= pos_in;
         skip_ff <= skip_in;
         left_ff <= left_in;
      end
      i_ff   <= i_in;
      cnt_ff <= cnt_in;
      sa_ff  <= sa_in;
      sb_ff  <= sb_in;
   end

   assign sts.init_done = cnt_ff[8];
   assign sts.ks_done   = cnt_ff[8];
   assign sts.skipping  = skip_ff;
   assign sts.run_done  = (left_ff == 7'd1);
   assign rsp.out_byte  = perm_rd ^ st_rd;
   assign rsp.last      = (left_ff == 7'd1);

endmodule

// File: rtl/keyed_rc4_stream_generator.sv
// ---------------------------------------------------------------------------
// keyed_rc4_stream_generator
// Top level: controller state machine and datapath for the keyed RC4
// keystream generator.
// ---------------------------------------------------------------------------
// Usage
//   An item is transferred when start is high and busy is low. The item
//   is a req_type: load writes one subkey byte, start rebuilds the
//   permutation and runs the key schedule, fetch returns 1..64 bytes.
//   Each result byte appears on rsp_data for one cycle with rsp_valid high;
//   rsp_data.last marks the final byte of a fetch. The receiver cannot
//   stall; results are sent as produced.
//   Load keeps busy low; the next item can follow next cycle.
//   Start keeps busy high through a clear, an identity fill, a clear,
//   per key byte a read, an index step and two swap writes, and a final
//   clear. Fetch, for each byte, steps a and reads S[a], reads S[b],
//   makes two swap writes, does the output read and then gives the
//   result; busy stays high until the last byte, so a new item waits.
//   A fetch that crosses the block end first walks the rest of the
//   block through the same steps with no results. This sequencing
//   follows from the single-port permutation RAM.
//   Reset: indices and block position clear; the permutation RAM is
//   rebuilt by an identity fill, with busy high until the fill is done.
// ---------------------------------------------------------------------------
module keyed_rc4_stream_generator import krc4_pkg::*; #(
   parameter int SUBKEY_BYTES = SUBKEY_BYTES_DEF,
   parameter int MAX_FETCH    = MAX_FETCH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;
   rsp_type rsp;

   krc4_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .operation(req_data.operation),
      .fetch_count(req_data.fetch_count), .sts(sts), .cmd(cmd), .busy(busy),
      .rsp_valid(rsp_valid)
   );

   krc4_datapath #(.SUBKEY_BYTES(SUBKEY_BYTES), .MAX_FETCH(MAX_FETCH)) u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd), .sts(sts), .rsp(rsp)
   );

   assign rsp_data = rsp;

endmodule

// File: rtl/krc4_ctrl.sv
// ---------------------------------------------------------------------------
// krc4_ctrl
// Controller state machine sequencing fill, key schedule and generation.
// ---------------------------------------------------------------------------
module krc4_ctrl import krc4_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] operation,
   input  logic [6:0] fetch_count,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   state_type state_ff, state_in;
   logic      first_ff, first_in;
   logic      key_ff, key_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         first_ff <= 1'b1;
         key_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         key_ff   <= key_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      first_in  = first_ff;
      key_in    = key_ff;
      cmd       = '0;
      busy      = (state_ff != ST_IDLE);
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (operation)
                  OP_LOAD:  cmd.store_wr = 1'b1;
                  OP_START: begin
                     cmd.init_clear = 1'b1;
                     first_in       = 1'b1;
                     key_in         = 1'b1;
                     state_in       = ST_INIT;
                  end
                  OP_FETCH: begin
                     if (fetch_count != 7'd0) begin
                        cmd.fetch_begin = 1'b1;
                        state_in        = ST_GEN_A;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // identity fill, then key schedule when started by a command
         ST_INIT: begin
            if (first_ff) begin
               cmd.init_clear = 1'b1;
               first_in       = 1'b0;
            end else if (sts.init_done) begin
               cmd.init_clear = 1'b1;
               key_in         = 1'b0;
               state_in       = (key_ff) ? ST_KS_RD : ST_IDLE;
            end else begin
               cmd.init_step = 1'b1;
            end
         end
         ST_KS_RD: begin
            if (sts.ks_done) begin
               cmd.init_clear = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.ks_rd = 1'b1;
               state_in  = ST_KS_J;
            end
         end
         ST_KS_J: begin
            cmd.ks_j = 1'b1;
            state_in = ST_KS_SW;
         end
         ST_KS_SW: begin
            cmd.ks_sw = 1'b1;
            state_in  = ST_KS_T;
         end
         ST_KS_T: begin
            cmd.ks_t = 1'b1;
            state_in = ST_KS_RD;
         end
         ST_GEN_A: begin
            cmd.gen_a = 1'b1;
            state_in  = ST_GEN_B;
         end
         ST_GEN_B: begin
            cmd.gen_b = 1'b1;
            state_in  = ST_GEN_SW;
         end
         ST_GEN_SW: begin
            cmd.gen_sw = 1'b1;
            state_in   = ST_GEN_T;
         end
         ST_GEN_T: begin
            cmd.gen_t = 1'b1;
            state_in  = ST_GEN_OUT;
         end
         ST_GEN_OUT: begin
            cmd.gen_out = 1'b1;
            state_in    = ST_GEN_RSP;
         end
         ST_GEN_RSP: begin
            // output data valid the cycle after the output read
            cmd.gen_rsp = 1'b1;
            rsp_valid   = !sts.skipping;
            state_in    = (!sts.skipping && sts.run_done) ? ST_IDLE : ST_GEN_A;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: rtl/krc4_checker.sv
// ---------------------------------------------------------------------------
// krc4_checker
// Port-level checks on the keyed RC4 generator, bound to the top level.
// ---------------------------------------------------------------------------
module krc4_checker import krc4_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // no result while idle
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");

   // results are never back to back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("results back to back");

   // busy after reset for the identity fill
   a_reset_busy: assert property (@(posedge clock)
      $past(reset) |-> busy) else $error("idle straight after reset");

   // no result in the cycle after a transfer
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid) else $error("result straight after transfer");

   // result payload is fully defined
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data)) else $error("unknown result payload");

endmodule

bind keyed_rc4_stream_generator krc4_checker u_krc4_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
